/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

/* src/aszs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package aszs_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int COUNT_W = 32;
    localparam int KEY_W = 32;

    localparam int ERR_OVERFLOW_BIT = 0;
    localparam int ERR_UNKNOWN_FREE_BIT = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STAT_RD,
        ST_MODIFY
    } state_t;

    typedef enum logic [1:0] {
        OUT_UPDATED  = 2'd0,
        OUT_NEW      = 2'd1,
        OUT_FULL     = 2'd2,
        OUT_NO_ENTRY = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] live;
        logic [COUNT_W-1:0] peak;
    } stats_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (&v) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

/* src/aszs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module aszs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/allocation_size_statistics.sv */
`timescale 1ns / 1ps
`default_nettype none
// an event scans the key memory from entry 0 up; a hit at entry k then passes
// through ST_STAT_RD and ST_MODIFY; a miss ends once all n entries in use (up to 256)
// are read and compared, or with no key read when the table is empty
// throughput: one event at a time, set by the key scan through the key memory,
// one entry read per cycle; busy stays high until the result beat on done
// reset clears the fsm, entry count and sticky errors; the memories are not cleared
// the receiver cannot stall: done is high for exactly one cycle per event

module allocation_size_statistics (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] alloc_size,
    input  wire logic        is_alloc,
    output logic             done,
    output logic [1:0]       outcome,
    output logic [7:0]       entry_index,
    output logic [31:0]      total_allocs,
    output logic [31:0]      live_blocks,
    output logic [31:0]      peak_live_blocks,
    output logic [8:0]       entries_used,
    output logic [1:0]       error_flags
);

    import aszs_pkg::*;

    state_t state_reg, state_next;

    logic [KEY_W-1:0] key_reg, key_next;
    logic             alloc_reg, alloc_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [1:0]       err_reg, err_next;

    logic             done_reg, done_next;
    outcome_t         outcome_reg, outcome_next;
    logic [7:0]       index_reg, index_next;
    stats_t           res_reg, res_next;

    logic             key_we;
    logic [KEY_W-1:0] key_rdata;
    logic             stat_we;
    logic [IDX_W-1:0] stat_waddr;
    stats_t           stat_wdata;
    stats_t           stat_rdata;
    stats_t           stat_mod;

    logic             accept;
    logic             hit;
    logic             issue;
    logic             miss;
    logic             full;

    aszs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    aszs_ram #(
        .WIDTH ($bits(stats_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .raddr (idx_reg),
        .rdata (stat_rdata)
    );

    assign accept = start && (state_reg == ST_IDLE);
    // compare the key read last cycle while the next address goes out
    assign hit    = cmp_valid_reg && (key_rdata == key_reg);
    assign issue  = scan_idx_reg < used_reg;
    assign miss   = !hit && !issue && !cmp_valid_reg;
    assign full   = used_reg == CNT_W'(TABLE_ENTRIES);

    always_comb
    begin
        stat_mod = stat_rdata;
        if (alloc_reg)
        begin
            stat_mod.total = sat_inc(stat_rdata.total);
            stat_mod.live  = sat_inc(stat_rdata.live);
            if (stat_mod.live > stat_rdata.peak)
            begin
                stat_mod.peak = stat_mod.live;
            end
        end
        else if (stat_rdata.live != '0)
        begin
            stat_mod.live = stat_rdata.live - COUNT_W'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_STAT_RD;
                end
                else if (miss)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STAT_RD:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result registers
    always_comb
    begin
        key_next       = key_reg;
        alloc_next     = alloc_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        err_next       = err_reg;
        done_next      = 1'b0;
        outcome_next   = outcome_reg;
        index_next     = index_reg;
        res_next       = res_reg;
        key_we         = 1'b0;
        stat_we        = 1'b0;
        stat_waddr     = idx_reg;
        stat_wdata     = stat_mod;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next       = alloc_size;
                    alloc_next     = is_alloc;
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    idx_next = cmp_idx_reg;
                end
                else if (issue)
                begin
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end

                if (miss)
                begin
                    done_next  = 1'b1;
                    index_next = '0;
                    res_next   = '0;
                    if (!alloc_reg)
                    begin
                        err_next[ERR_UNKNOWN_FREE_BIT] = 1'b1;
                        outcome_next = OUT_NO_ENTRY;
                    end
                    else if (full)
                    begin
                        err_next[ERR_OVERFLOW_BIT] = 1'b1;
                        outcome_next = OUT_FULL;
                    end
                    else
                    begin
                        key_we       = 1'b1;
                        stat_we      = 1'b1;
                        stat_waddr   = used_reg[IDX_W-1:0];
                        stat_wdata   = '{total: COUNT_W'(1), live: COUNT_W'(1),
                                         peak: COUNT_W'(1)};
                        used_next    = used_reg + CNT_W'(1);
                        outcome_next = OUT_NEW;
                        index_next   = 8'(used_reg);
                        res_next     = stat_wdata;
                    end
                end
            end
            ST_STAT_RD:
            begin
            end
            ST_MODIFY:
            begin
                stat_we      = 1'b1;
                done_next    = 1'b1;
                outcome_next = OUT_UPDATED;
                index_next   = 8'(idx_reg);
                res_next     = stat_mod;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            used_reg      <= '0;
            err_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            used_reg      <= used_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        alloc_reg    <= alloc_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        idx_reg      <= idx_next;
        outcome_reg  <= outcome_next;
        index_reg    <= index_next;
        res_reg      <= res_next;
    end

    assign busy             = state_reg != ST_IDLE;
    assign done             = done_reg;
    assign outcome          = outcome_reg;
    assign entry_index      = index_reg;
    assign total_allocs     = res_reg.total;
    assign live_blocks      = res_reg.live;
    assign peak_live_blocks = res_reg.peak;
    assign entries_used     = 9'(used_reg);
    assign error_flags      = err_reg;

endmodule

`default_nettype wire

/* src/aszs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aszs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [31:0] alloc_size,
    input wire logic        is_alloc,
    input wire logic        done,
    input wire logic [1:0]  outcome,
    input wire logic [7:0]  entry_index,
    input wire logic [31:0] total_allocs,
    input wire logic [31:0] live_blocks,
    input wire logic [31:0] peak_live_blocks,
    input wire logic [8:0]  entries_used,
    input wire logic [1:0]  error_flags
);

    import aszs_pkg::*;

    logic no_entry;
    logic new_entry;
    logic side_in;

    assign no_entry  = (outcome == OUT_FULL) || (outcome == OUT_NO_ENTRY);
    assign new_entry = outcome == OUT_NEW;
    // payload inputs only matter on an accepted beat
    assign side_in   = ^{alloc_size, is_alloc} || 1'b1;

    `ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy && side_in, busy)
    `ASSERT_IMPLIES(a_done_ends_busy, clk, rst_n, done, !busy && $past(busy))
    `ASSERT_IMPLIES(a_no_entry_zero, clk, rst_n, done && no_entry,
        entry_index == 8'd0 && total_allocs == 32'd0 && live_blocks == 32'd0 &&
        peak_live_blocks == 32'd0)
    `ASSERT_IMPLIES(a_new_entry_ones, clk, rst_n, done && new_entry,
        total_allocs == 32'd1 && live_blocks == 32'd1 && peak_live_blocks == 32'd1 &&
        entries_used != 9'd0)
    `ASSERT_NEXT(a_errors_sticky, clk, rst_n, 1'b1,
        (error_flags & $past(error_flags)) == $past(error_flags))

endmodule

bind allocation_size_statistics aszs_checker u_aszs_checker (.*);

`default_nettype wire
